[hw/rtl/pcgs_pkg.sv]
// shared types, codes and sizes of the packed cell grid store
package pcgs_pkg;

	// fixed field widths
	localparam int CELL_W   = 3;
	localparam int MODE_W   = 3;
	localparam int COORD_W  = 4;
	localparam int DIM_W    = 5;
	localparam int STATUS_W = 2;

	// default grid limits
	localparam int DEF_MAX_ROWS = 16;
	localparam int DEF_MAX_COLS = 16;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_READ    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_INS_ROW = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DEL_ROW = 3'd4;
	localparam logic [MODE_W-1:0] MODE_INS_COL = 3'd5;
	localparam logic [MODE_W-1:0] MODE_DEL_COL = 3'd6;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SIZE  = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] column;
		logic [CELL_W-1:0]  value;
		logic [DIM_W-1:0]   position;
		logic [DIM_W-1:0]   new_rows;
		logic [DIM_W-1:0]   new_cols;
	} op_t;

	typedef struct packed {
		logic [CELL_W-1:0]   cell_value;
		logic [DIM_W-1:0]    rows_now;
		logic [DIM_W-1:0]    cols_now;
		logic [STATUS_W-1:0] status;
	} res_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SWEEP,
		S_DRAIN
	} state_t;

	typedef enum logic [2:0] {
		K_CREATE,
		K_INS_ROW,
		K_DEL_ROW,
		K_INS_COL,
		K_DEL_COL
	} kind_t;

endpackage

[hw/rtl/packed_cell_grid_store.sv]
// packed cell grid store: top level with sequencer, bank pair and result register
//
// A grid of up to MAX_ROWS x MAX_COLS cells of three bits, kept row-major (cell
// row*cols+column) in one of two equal memories; the other memory is the
// scratch bank. Each request is one operation: create, read, write, insert or
// delete a row or a column. A read presents the address, then loads the
// registered read data into the result register. A write, a rejected request
// and the unused mode load their result on acceptance. Create, insert and
// delete rebuild the grid into the scratch bank one cell per cycle, reading
// the live bank and writing the scratch bank in a two-stage pipe, then swap
// banks. Create writes zeros over its new cells, so no clearing pass runs
// after reset (no cell is live until a rebuild writes it). Results leave
// through a registered output; a request is taken only while the block is
// idle and the result register is empty or its result leaves in the same
// cycle, so a stalled result holds off the next request. empty_code is
// written through the cfg port, which is always ready, and must only change
// while no request is in flight.
module packed_cell_grid_store
	import pcgs_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              op_valid,
	output logic              op_stall,
	input  op_t               op,
	// result channel
	output logic              res_valid,
	input  logic              res_stall,
	output res_t              res,
	// empty_code register write
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CELL_W-1:0] cfg_data
);

	// sizes
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RC_W  = $clog2(MAX_ROWS + 1);            // row count
	localparam int CC_W  = $clog2(MAX_COLS + 1);            // column count
	localparam int RI_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;   // row index
	localparam int CI_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;   // column index
	localparam int LW0   = (RC_W > CC_W) ? RC_W : CC_W;
	localparam int LW    = (LW0 > DIM_W) ? LW0 : DIM_W;     // compare width
	localparam int PW    = LW + CC_W + 1;                   // linear index product

	// control state
	state_t            state_q, state_d;
	logic              bank_q;
	logic [RC_W-1:0]   row_count_q;
	logic [CC_W-1:0]   col_count_q;
	logic [CELL_W-1:0] empty_code_q;
	logic              res_valid_q;
	logic              valid_s1;

	// sweep payload
	kind_t             kind_q;
	logic [DIM_W-1:0]  pos_q;
	logic [RC_W-1:0]   new_rows_q;
	logic [CC_W-1:0]   new_cols_q;
	logic [RI_W-1:0]   r_q;
	logic [CI_W-1:0]   c_q;
	logic [AW-1:0]     k_q;
	logic [AW-1:0]     k_s1;
	logic              fill_s1;
	res_t              res_q;

	// handshakes
	logic res_free;
	logic accept;

	assign res_free  = !res_valid_q || !res_stall;
	assign op_stall  = (state_q != S_IDLE) || !res_free;
	assign accept    = op_valid && !op_stall;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// widened views for compares
	logic [LW-1:0] rows_x, cols_x, pos_in_x, nr_x, nc_x, row_x, col_x;

	assign rows_x   = LW'(row_count_q);
	assign cols_x   = LW'(col_count_q);
	assign pos_in_x = LW'(op.position);
	assign nr_x     = LW'(op.new_rows);
	assign nc_x     = LW'(op.new_cols);
	assign row_x    = LW'(op.row);
	assign col_x    = LW'(op.column);

	// linear cell index of a read or write request
	logic [PW-1:0] op_lin;
	assign op_lin = PW'(row_x) * PW'(col_count_q) + PW'(col_x);

	// request decode (fsm outputs)
	logic                imm_load;
	logic [STATUS_W-1:0] imm_status;
	logic                go_read;
	logic                go_sweep;
	logic                sw_empty;
	logic                wr_op;
	kind_t               sw_kind;
	logic [RC_W-1:0]     sw_rows;
	logic [CC_W-1:0]     sw_cols;
	logic                issue;
	logic                read_load;
	logic                drain_done;

	always_comb begin
		imm_load   = 1'b0;
		imm_status = ST_OK;
		go_read    = 1'b0;
		go_sweep   = 1'b0;
		wr_op      = 1'b0;
		sw_kind    = K_CREATE;
		sw_rows    = row_count_q;
		sw_cols    = col_count_q;
		if (accept) begin
			case (op.mode)
				MODE_CREATE: begin
					if (nr_x > LW'(MAX_ROWS) || nc_x > LW'(MAX_COLS)) begin
						imm_load   = 1'b1;
						imm_status = ST_SIZE;
					end else begin
						go_sweep = 1'b1;
						sw_kind  = K_CREATE;
						sw_rows  = RC_W'(op.new_rows);
						sw_cols  = CC_W'(op.new_cols);
					end
				end
				MODE_READ, MODE_WRITE: begin
					if (row_x >= rows_x || col_x >= cols_x) begin
						imm_load   = 1'b1;
						imm_status = ST_RANGE;
					end else if (op.mode == MODE_READ) begin
						go_read = 1'b1;
					end else begin
						imm_load = 1'b1;
						wr_op    = 1'b1;
					end
				end
				MODE_INS_ROW: begin
					if (pos_in_x > rows_x) begin
						imm_load   = 1'b1;
						imm_status = ST_RANGE;
					end else if (rows_x >= LW'(MAX_ROWS)) begin
						imm_load   = 1'b1;
						imm_status = ST_SIZE;
					end else begin
						go_sweep = 1'b1;
						sw_kind  = K_INS_ROW;
						sw_rows  = RC_W'(rows_x + LW'(1));
					end
				end
				MODE_DEL_ROW: begin
					if (pos_in_x >= rows_x) begin
						imm_load   = 1'b1;
						imm_status = ST_RANGE;
					end else begin
						go_sweep = 1'b1;
						sw_kind  = K_DEL_ROW;
						sw_rows  = RC_W'(rows_x - LW'(1));
					end
				end
				MODE_INS_COL: begin
					if (pos_in_x > cols_x) begin
						imm_load   = 1'b1;
						imm_status = ST_RANGE;
					end else if (cols_x >= LW'(MAX_COLS)) begin
						imm_load   = 1'b1;
						imm_status = ST_SIZE;
					end else begin
						go_sweep = 1'b1;
						sw_kind  = K_INS_COL;
						sw_cols  = CC_W'(cols_x + LW'(1));
					end
				end
				MODE_DEL_COL: begin
					if (pos_in_x >= cols_x) begin
						imm_load   = 1'b1;
						imm_status = ST_RANGE;
					end else begin
						go_sweep = 1'b1;
						sw_kind  = K_DEL_COL;
						sw_cols  = CC_W'(cols_x - LW'(1));
					end
				end
				default: begin
					// unused mode: report ok, touch nothing
					imm_load = 1'b1;
				end
			endcase
		end
		sw_empty   = (sw_rows == '0) || (sw_cols == '0);
		issue      = (state_q == S_SWEEP);
		read_load  = (state_q == S_READ);
		drain_done = (state_q == S_DRAIN);
	end

	// sweep position and source cell for the current destination cell
	logic [LW-1:0] r_x, c_x, pos_x, sr_x, sc_x;
	logic          fill;
	logic          sweep_last;
	logic          col_last;
	logic [PW-1:0] src_lin;

	assign r_x   = LW'(r_q);
	assign c_x   = LW'(c_q);
	assign pos_x = LW'(pos_q);

	always_comb begin
		fill = 1'b0;
		sr_x = r_x;
		sc_x = c_x;
		case (kind_q)
			K_CREATE: begin
				fill = 1'b1;
			end
			K_INS_ROW: begin
				if (r_x == pos_x) begin
					fill = 1'b1;
				end else if (r_x > pos_x) begin
					sr_x = r_x - LW'(1);
				end
			end
			K_DEL_ROW: begin
				if (r_x >= pos_x) begin
					sr_x = r_x + LW'(1);
				end
			end
			K_INS_COL: begin
				if (c_x == pos_x) begin
					fill = 1'b1;
				end else if (c_x > pos_x) begin
					sc_x = c_x - LW'(1);
				end
			end
			K_DEL_COL: begin
				if (c_x >= pos_x) begin
					sc_x = c_x + LW'(1);
				end
			end
			default: begin
				fill = 1'b1;
			end
		endcase
	end

	// source index uses the old column count, which holds until the swap
	assign src_lin    = PW'(sr_x) * PW'(col_count_q) + PW'(sc_x);
	assign col_last   = (c_x == LW'(new_cols_q) - LW'(1));
	assign sweep_last = col_last && (r_x == LW'(new_rows_q) - LW'(1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (go_read) begin
					state_d = S_READ;
				end else if (go_sweep) begin
					state_d = sw_empty ? S_DRAIN : S_SWEEP;
				end
			end
			S_READ: begin
				state_d = S_IDLE;
			end
			S_SWEEP: begin
				if (sweep_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// bank pair: live bank is read, scratch bank takes the rebuilt grid
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata [2];
	logic              ram_we    [2];
	logic [AW-1:0]     ram_waddr [2];
	logic [CELL_W-1:0] ram_wdata [2];
	logic [CELL_W-1:0] live_rdata;
	logic [CELL_W-1:0] fill_val;

	assign ram_raddr  = issue ? src_lin[AW-1:0] : op_lin[AW-1:0];
	assign live_rdata = ram_rdata[bank_q];
	assign fill_val   = (kind_q == K_CREATE) ? '0 : empty_code_q;

	for (genvar b = 0; b < 2; b++) begin : g_bank
		logic is_live;
		assign is_live      = (bank_q == 1'(b));
		// single cell write lands in the live bank, sweep writes the scratch bank
		assign ram_we[b]    = (wr_op && is_live) || (valid_s1 && !is_live);
		assign ram_waddr[b] = is_live ? op_lin[AW-1:0] : k_s1;
		assign ram_wdata[b] = is_live ? op.value : (fill_s1 ? fill_val : live_rdata);

		pcgs_ram #(
			.WIDTH(CELL_W),
			.DEPTH(DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (ram_we[b]),
			.waddr(ram_waddr[b]),
			.wdata(ram_wdata[b]),
			.raddr(ram_raddr),
			.rdata(ram_rdata[b])
		);
	end

	// result selection
	res_t res_d;
	logic res_load;

	assign res_load = imm_load || read_load || drain_done;

	always_comb begin
		res_d.cell_value = '0;
		res_d.rows_now   = DIM_W'(row_count_q);
		res_d.cols_now   = DIM_W'(col_count_q);
		res_d.status     = ST_OK;
		if (read_load) begin
			res_d.cell_value = live_rdata;
		end else if (drain_done) begin
			res_d.rows_now = DIM_W'(new_rows_q);
			res_d.cols_now = DIM_W'(new_cols_q);
		end else begin
			res_d.status = imm_status;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			bank_q       <= 1'b0;
			row_count_q  <= '0;
			col_count_q  <= '0;
			empty_code_q <= '0;
			res_valid_q  <= 1'b0;
			valid_s1     <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			if (cfg_valid) begin
				empty_code_q <= cfg_data;
			end
			if (drain_done) begin
				bank_q      <= ~bank_q;
				row_count_q <= new_rows_q;
				col_count_q <= new_cols_q;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// sweep pipe and result payload
	always_ff @(posedge clk) begin
		if (go_sweep) begin
			kind_q     <= sw_kind;
			pos_q      <= op.position;
			new_rows_q <= sw_rows;
			new_cols_q <= sw_cols;
			r_q        <= '0;
			c_q        <= '0;
			k_q        <= '0;
		end else if (issue) begin
			k_q <= k_q + AW'(1);
			if (col_last) begin
				c_q <= '0;
				r_q <= r_q + RI_W'(1);
			end else begin
				c_q <= c_q + CI_W'(1);
			end
		end
		k_s1    <= k_q;
		fill_s1 <= fill;
		if (res_load) begin
			res_q <= res_d;
		end
	end

	// checks
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(bank_q) |-> $past(state_q == S_DRAIN))
		else $error("bank swap outside the end of a rebuild");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(state_q == S_SWEEP))
		else $error("scratch write without a sweep read the cycle before");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ || state_q == S_DRAIN) |-> !res_valid_q)
		else $error("result register busy when a result is due");

	assert property (@(posedge clk) disable iff (!arst_n)
		LW'(row_count_q) <= LW'(MAX_ROWS) && LW'(col_count_q) <= LW'(MAX_COLS))
		else $error("grid dimensions beyond limits");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> (r_x < LW'(new_rows_q) && c_x < LW'(new_cols_q)))
		else $error("sweep position outside the new grid");

endmodule

[hw/rtl/pcgs_ram.sv]
// generic simple dual port ram with registered read
module pcgs_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[tb/testbench.sv]
// self-checking testbench for the packed cell grid store
module testbench
	import pcgs_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	// grid limits the block is built with
	localparam int GRID_ROWS = DEF_MAX_ROWS;
	localparam int GRID_COLS = DEF_MAX_COLS;
	localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;
	// the package has no name for the spare mode code
	localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
	// settle wait, longer than the rebuild of a full grid, with margin
	localparam int SETTLE_CYCLES = GRID_CELLS + 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic op_valid = 1'b0;
	logic op_stall;
	op_t op = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CELL_W-1:0] cfg_data = '0;

	// predicted contents: cell k of the row-major grid, plus dimensions and fill code
	logic [CELL_W-1:0] grid_cells [GRID_CELLS];
	int grid_rows = 0;
	int grid_cols = 0;
	logic [CELL_W-1:0] fill_code = '0;

	// results the block still owes, oldest first
	res_t owed_results [$];

	// idling percentages of the current phase
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;

	int n_errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_rejected = 0;
	int n_rebuilds = 0;
	int n_codes = 0;

	packed_cell_grid_store u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_stall  (op_stall),
		.op        (op),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// run limit, far beyond the slowest legal run
	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// rebuild the grid with one line opened or closed at pos
	function automatic void rebuild_grid(kind_t k, int pos);
		logic [CELL_W-1:0] fresh [GRID_CELLS];
		int nr;
		int nc;
		int sr;
		int sc;
		bit fill;
		nr = grid_rows;
		nc = grid_cols;
		case (k)
			K_INS_ROW: nr = grid_rows + 1;
			K_DEL_ROW: nr = grid_rows - 1;
			K_INS_COL: nc = grid_cols + 1;
			K_DEL_COL: nc = grid_cols - 1;
			default: ;
		endcase
		foreach (fresh[i])
			fresh[i] = '0;
		for (int r = 0; r < nr; r++) begin
			for (int c = 0; c < nc; c++) begin
				sr = r;
				sc = c;
				fill = 1'b0;
				case (k)
					K_INS_ROW: begin
						if (r == pos)
							fill = 1'b1;
						else if (r > pos)
							sr = r - 1;
					end
					K_DEL_ROW: begin
						if (r >= pos)
							sr = r + 1;
					end
					K_INS_COL: begin
						if (c == pos)
							fill = 1'b1;
						else if (c > pos)
							sc = c - 1;
					end
					K_DEL_COL: begin
						if (c >= pos)
							sc = c + 1;
					end
					default: ;
				endcase
				fresh[r * nc + c] = fill ? fill_code : grid_cells[sr * grid_cols + sc];
			end
		end
		grid_cells = fresh;
		grid_rows = nr;
		grid_cols = nc;
		n_rebuilds++;
	endfunction

	// apply one request to the predicted grid and return the result it owes
	function automatic res_t apply_grid_op(op_t o);
		res_t r;
		r = '0;
		r.status = ST_OK;
		case (o.mode)
			MODE_CREATE: begin
				if (int'(o.new_rows) > GRID_ROWS || int'(o.new_cols) > GRID_COLS) begin
					r.status = ST_SIZE;
				end else begin
					foreach (grid_cells[i])
						grid_cells[i] = '0;
					grid_rows = int'(o.new_rows);
					grid_cols = int'(o.new_cols);
				end
			end
			MODE_READ, MODE_WRITE: begin
				if (int'(o.row) >= grid_rows || int'(o.column) >= grid_cols)
					r.status = ST_RANGE;
				else if (o.mode == MODE_READ)
					r.cell_value = grid_cells[int'(o.row) * grid_cols + int'(o.column)];
				else
					grid_cells[int'(o.row) * grid_cols + int'(o.column)] = o.value;
			end
			MODE_INS_ROW: begin
				// position is checked before the size limit
				if (int'(o.position) > grid_rows)
					r.status = ST_RANGE;
				else if (grid_rows >= GRID_ROWS)
					r.status = ST_SIZE;
				else
					rebuild_grid(K_INS_ROW, int'(o.position));
			end
			MODE_DEL_ROW: begin
				if (int'(o.position) >= grid_rows)
					r.status = ST_RANGE;
				else
					rebuild_grid(K_DEL_ROW, int'(o.position));
			end
			MODE_INS_COL: begin
				if (int'(o.position) > grid_cols)
					r.status = ST_RANGE;
				else if (grid_cols >= GRID_COLS)
					r.status = ST_SIZE;
				else
					rebuild_grid(K_INS_COL, int'(o.position));
			end
			MODE_DEL_COL: begin
				if (int'(o.position) >= grid_cols)
					r.status = ST_RANGE;
				else
					rebuild_grid(K_DEL_COL, int'(o.position));
			end
			default: ;
		endcase
		r.rows_now = DIM_W'(grid_rows);
		r.cols_now = DIM_W'(grid_cols);
		return r;
	endfunction

	function automatic op_t make_op(logic [MODE_W-1:0] m, int row, int column, int value,
			int position, int nr, int nc);
		op_t o;
		o.mode = m;
		o.row = COORD_W'(row);
		o.column = COORD_W'(column);
		o.value = CELL_W'(value);
		o.position = DIM_W'(position);
		o.new_rows = DIM_W'(nr);
		o.new_cols = DIM_W'(nc);
		return o;
	endfunction

	// random request, mostly legal for the current grid, all fields noisy
	function automatic op_t pick_grid_op();
		op_t o;
		int pick;
		int lines;
		o = $bits(op_t)'($urandom);
		pick = $urandom_range(99);
		// an empty grid rejects reads, writes and deletes, so create one half the time
		if ((grid_rows == 0 || grid_cols == 0) && pick < 50)
			pick = 0;
		if (pick < 5) begin
			o.mode = MODE_CREATE;
			case ($urandom_range(9))
				0: o.new_rows = DIM_W'($urandom_range(31, 17));
				1: begin
					o.new_rows = DIM_W'($urandom_range(GRID_ROWS));
					o.new_cols = DIM_W'($urandom_range(GRID_COLS));
				end
				default: begin
					o.new_rows = DIM_W'($urandom_range(5, 1));
					o.new_cols = DIM_W'($urandom_range(5, 1));
				end
			endcase
		end else if (pick < 7) begin
			o.mode = MODE_UNUSED;
		end else if (pick < 57) begin
			o.mode = (pick < 32) ? MODE_WRITE : MODE_READ;
			if (grid_rows > 0 && grid_cols > 0 && $urandom_range(9) != 0) begin
				o.row = COORD_W'($urandom_range(grid_rows - 1));
				o.column = COORD_W'($urandom_range(grid_cols - 1));
			end
		end else begin
			case (pick % 4)
				0: o.mode = MODE_INS_ROW;
				1: o.mode = MODE_DEL_ROW;
				2: o.mode = MODE_INS_COL;
				default: o.mode = MODE_DEL_COL;
			endcase
			// keep grids small so rebuilds stay short
			if (grid_rows * grid_cols > 48 && $urandom_range(3) != 0) begin
				if (o.mode == MODE_INS_ROW)
					o.mode = MODE_DEL_ROW;
				else if (o.mode == MODE_INS_COL)
					o.mode = MODE_DEL_COL;
			end
			lines = (o.mode == MODE_INS_ROW || o.mode == MODE_DEL_ROW) ? grid_rows : grid_cols;
			// one in ten keeps its random position
			if ($urandom_range(9) != 0) begin
				if (o.mode == MODE_INS_ROW || o.mode == MODE_INS_COL)
					o.position = DIM_W'($urandom_range(lines));
				else if (lines > 0)
					o.position = DIM_W'($urandom_range(lines - 1));
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	// send one request; valid stays high so the next one can follow at once
	task automatic issue_request(op_t o);
		int gap;
		res_t want;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			op_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op_valid <= 1'b1;
		op <= o;
		@(posedge clk);
		while (op_stall)
			@(posedge clk);
		// accepted at this edge
		want = apply_grid_op(o);
		owed_results.push_back(want);
		n_sent++;
		if (want.status != ST_OK)
			n_rejected++;
	endtask

	// drop valid and hold off until every owed result has come back
	task automatic wait_grid_idle();
		op_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
	endtask

	// empty_code changes only with nothing in flight
	task automatic set_empty_code(logic [CELL_W-1:0] code);
		wait_grid_idle();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= code;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		fill_code = code;
		n_codes++;
		cfg_valid <= 1'b0;
	endtask

	// receiver stalls at random at the current phase's rate
	always @(posedge clk)
		res_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);

	// compare each accepted result with the oldest owed one
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (owed_results.size() == 0) begin
				report_mismatch("result with nothing owed, status", int'(res.status), -1);
			end else begin
				want = owed_results.pop_front();
				n_checked++;
				if (res.cell_value !== want.cell_value)
					report_mismatch("cell_value", int'(res.cell_value),
						int'(want.cell_value));
				if (res.rows_now !== want.rows_now)
					report_mismatch("rows_now", int'(res.rows_now), int'(want.rows_now));
				if (res.cols_now !== want.cols_now)
					report_mismatch("cols_now", int'(res.cols_now), int'(want.cols_now));
				if (res.status !== want.status)
					report_mismatch("status", int'(res.status), int'(want.status));
			end
		end
	end

	// empty grid, oversize creates, rejected lines, growth from nothing
	task automatic test_empty_grid();
		issue_request(make_op(MODE_CREATE, 0, 0, 0, 0, 17, 4));
		issue_request(make_op(MODE_CREATE, 0, 0, 0, 0, 4, 31));
		issue_request(make_op(MODE_CREATE, 0, 0, 0, 0, 0, 0));
		issue_request(make_op(MODE_READ, 0, 0, 0, 0, 0, 0));
		issue_request(make_op(MODE_DEL_ROW, 0, 0, 0, 0, 0, 0));
		issue_request(make_op(MODE_DEL_COL, 0, 0, 0, 0, 0, 0));
		issue_request(make_op(MODE_INS_ROW, 0, 0, 0, 1, 0, 0));
		// a row then a column out of nothing, filled with the reset code
		issue_request(make_op(MODE_INS_ROW, 0, 0, 0, 0, 0, 0));
		issue_request(make_op(MODE_INS_COL, 0, 0, 0, 0, 0, 0));
		issue_request(make_op(MODE_READ, 0, 0, 0, 0, 0, 0));
	endtask

	// full grid: corner cells, a cell in row 0, inserts at the limit, edge deletes
	task automatic test_full_grid();
		set_empty_code(3'd7);
		issue_request(make_op(MODE_CREATE, 0, 0, 0, 0, 16, 16));
		issue_request(make_op(MODE_WRITE, 15, 15, 7, 0, 0, 0));
		issue_request(make_op(MODE_WRITE, 0, 0, 5, 0, 0, 0));
		// cell 2 of row 0, read back below
		issue_request(make_op(MODE_WRITE, 0, 2, 6, 0, 0, 0));
		issue_request(make_op(MODE_READ, 15, 15, 0, 0, 0, 0));
		issue_request(make_op(MODE_READ, 0, 2, 0, 0, 0, 0));
		issue_request(make_op(MODE_INS_ROW, 0, 0, 0, 3, 0, 0));
		// bad position wins over the size limit
		issue_request(make_op(MODE_INS_COL, 0, 0, 0, 17, 0, 0));
		issue_request(make_op(MODE_DEL_ROW, 0, 0, 0, 15, 0, 0));
		issue_request(make_op(MODE_DEL_COL, 0, 0, 0, 0, 0, 0));
		issue_request(make_op(MODE_INS_ROW, 0, 0, 0, 15, 0, 0));
		issue_request(make_op(MODE_READ, 15, 14, 0, 0, 0, 0));
		issue_request(make_op(MODE_WRITE, 15, 15, 1, 0, 0, 0));
		issue_request(make_op(MODE_UNUSED, 15, 15, 7, 31, 31, 31));
		issue_request(make_op(MODE_READ, 0, 1, 0, 0, 0, 0));
	endtask

	// random traffic under one idling profile, with a full drain halfway
	task automatic test_random_traffic(int count, int tx_pct, int rx_pct,
			logic [CELL_W-1:0] code);
		set_empty_code(code);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		issue_request(make_op(MODE_CREATE, 0, 0, 0, 0, $urandom_range(5, 2),
			$urandom_range(5, 2)));
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				wait_grid_idle();
			issue_request(pick_grid_op());
		end
	endtask

	initial begin
		// sender 17 percent idle, receiver 72 percent stalled
		tx_idle_pct = 17;
		rx_stall_pct = 72;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_grid();
		test_full_grid();
		test_random_traffic(300, 17, 72, 3'($urandom_range(6, 1)));
		test_random_traffic(300, 72, 17, 3'd0);
		test_random_traffic(300, 0, 0, 3'($urandom));

		// let the last rebuild finish and catch any stray result
		wait_grid_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (owed_results.size() != 0)
			report_mismatch("results never delivered", 0, owed_results.size());

		$display("summary: %0d requests, %0d results checked, %0d rejected, %0d rebuilds",
			n_sent, n_checked, n_rejected, n_rebuilds);
		$display("summary: %0d empty_code writes, idle profiles 17/72, 72/17 and none",
			n_codes);
		if (n_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
